/* src/sm4_pkg.sv */
// Shared types, constants and tables for the SM4 block cipher.
`timescale 1ns / 1ps

package sm4_pkg;

  typedef logic [31:0] word_t;

  // The cipher always runs 32 rounds, so a round index is 5 bits wide.
  localparam int RoundCount = 32;
  localparam int RndW       = $clog2(RoundCount);

  typedef logic [RndW-1:0] rnd_t;

  localparam rnd_t LastRound = rnd_t'(RoundCount - 1);

  // System parameter FK, XORed into the key words before expansion.
  localparam word_t FK [4] = '{32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC};

  // Substitution box.
  localparam logic [7:0] SBOX [256] = '{
    8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7,
    8'h16, 8'hB6, 8'h14, 8'hC2, 8'h28, 8'hFB, 8'h2C, 8'h05,
    8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
    8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9C, 8'h42, 8'h50, 8'hF4, 8'h91, 8'hEF, 8'h98, 8'h7A,
    8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
    8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95,
    8'h80, 8'hDF, 8'h94, 8'hFA, 8'h75, 8'h8F, 8'h3F, 8'hA6,
    8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
    8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8,
    8'h68, 8'h6B, 8'h81, 8'hB2, 8'h71, 8'h64, 8'hDA, 8'h8B,
    8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
    8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2,
    8'h25, 8'h22, 8'h7C, 8'h3B, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
    8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E,
    8'hEA, 8'hBF, 8'h8A, 8'hD2, 8'h40, 8'hC7, 8'h38, 8'hB5,
    8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
    8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55,
    8'hAD, 8'h93, 8'h32, 8'h30, 8'hF5, 8'h8C, 8'hB1, 8'hE3,
    8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
    8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F,
    8'hD5, 8'hDB, 8'h37, 8'h45, 8'hDE, 8'hFD, 8'h8E, 8'h2F,
    8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
    8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F,
    8'h11, 8'hD9, 8'h5C, 8'h41, 8'h1F, 8'h10, 8'h5A, 8'hD8,
    8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
    8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0,
    8'h89, 8'h69, 8'h97, 8'h4A, 8'h0C, 8'h96, 8'h77, 8'h7E,
    8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
    8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20,
    8'h79, 8'hEE, 8'h5F, 8'h3E, 8'hD7, 8'hCB, 8'h39, 8'h48
  };

  // Round constant CK: byte j of constant i is (4*i + j) * 7, modulo 256.
  function automatic word_t round_const(input rnd_t idx);
    logic [7:0] base;
    logic [7:0] pos;
    word_t      c;
    base = {1'b0, idx, 2'b00};
    c    = '0;
    for (int j = 0; j < 4; j++) begin
      pos = base + 8'(j);
      c   = {c[23:0], 8'((pos << 3) - pos)};
    end
    return c;
  endfunction

endpackage

/* src/sm4_round.sv */
// Shared SM4 round unit: S-box layer plus linear map, for data and key rounds.
`timescale 1ns / 1ps

module sm4_round
  import sm4_pkg::*;
(
  input  word_t x0,
  input  word_t x1,
  input  word_t x2,
  input  word_t x3,
  input  word_t rk,
  input  logic  key_sched,
  output word_t nx
);

  word_t t_in;
  word_t b;
  word_t lin_data;
  word_t lin_key;

  // Mix the three upper words with the round key or round constant.
  assign t_in = x1 ^ x2 ^ x3 ^ rk;

  // Byte-wise substitution.
  assign b = {SBOX[t_in[31:24]], SBOX[t_in[23:16]], SBOX[t_in[15:8]], SBOX[t_in[7:0]]};

  // L for data rounds, L' for key expansion rounds.
  assign lin_data = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                      ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
  assign lin_key  = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};

  assign nx = x0 ^ (key_sched ? lin_key : lin_data);

endmodule

/* src/sm4_block_cipher.sv */
// Top level of the SM4 block cipher: sequencer, key and round-key storage.
//
//   Channel | Direction | Ports                                        | Moves
//   --------+-----------+----------------------------------------------+------------------
//   in      | sink      | in_valid, in_ready, in_block_word0..3        | one 128-bit block
//   out     | source    | out_valid, out_ready, out_result_word0..3    | one 128-bit block
//   cfg     | sink      | cfg_valid, cfg_ready, cfg_index, cfg_data    | one register write
//
// A block passes through the accept state, a load state that loads the working words and
// reads the first round key, and 32 rounds, one per cycle through the single shared round
// unit. The first block after a key write first runs key expansion through the same
// unit. Reset is synchronous and active low and clears the sequencer, the key-ready
// flag, the output valid flag, the mode and the key registers; the round-key memory
// needs no clearing. The result waits in an output register, so a new block can be
// taken meanwhile; the last round stalls while it is full.
`timescale 1ns / 1ps

module sm4_block_cipher
  import sm4_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  word_t       in_block_word0,
  input  word_t       in_block_word1,
  input  word_t       in_block_word2,
  input  word_t       in_block_word3,

  output logic        out_valid,
  input  logic        out_ready,
  output word_t       out_result_word0,
  output word_t       out_result_word1,
  output word_t       out_result_word2,
  output word_t       out_result_word3,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  word_t       cfg_data
);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXPAND = 2'd1;
  localparam logic [1:0] ST_LOAD   = 2'd2;
  localparam logic [1:0] ST_ROUND  = 2'd3;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_MODE = 3'd4;

  logic [1:0] state_r, state_nxt;
  rnd_t       cnt_r, cnt_nxt;
  logic       keys_ready_r, keys_ready_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       mode_r;
  word_t      key_r   [4];
  word_t      blk_r   [4];
  word_t      w_r     [4];
  word_t      w_nxt   [4];
  word_t      res_r   [4];
  word_t      rk_mem  [RoundCount];
  word_t      rk_q_r;
  word_t      rk_in;
  word_t      nx;
  logic       in_xfer;
  logic       cfg_xfer;
  logic       out_free;
  logic       last_round;
  logic       advance;
  logic       finish;
  logic       rk_rd_en;
  rnd_t       rd_idx;
  rnd_t       rd_addr;

  assign in_xfer    = in_valid && in_ready;
  assign cfg_xfer   = cfg_valid && cfg_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign last_round = (cnt_r == LastRound);
  assign advance    = (state_r == ST_ROUND) && (!last_round || out_free);
  assign finish     = (state_r == ST_ROUND) && last_round && out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Shared round unit; key expansion feeds it the round constant instead of a key.
  assign rk_in = (state_r == ST_EXPAND) ? round_const(cnt_r) : rk_q_r;

  sm4_round u_round (
    .x0        (w_r[0]),
    .x1        (w_r[1]),
    .x2        (w_r[2]),
    .x3        (w_r[3]),
    .rk        (rk_in),
    .key_sched (state_r == ST_EXPAND),
    .nx        (nx)
  );

  // Round-key read address runs one round ahead; decryption reads in reverse.
  assign rd_idx   = (state_r == ST_LOAD) ? '0 : cnt_r + rnd_t'(1);
  assign rd_addr  = mode_r ? ~rd_idx : rd_idx;
  assign rk_rd_en = (state_r == ST_LOAD) || advance;

  // Sequencer and control next state.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    keys_ready_nxt = keys_ready_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_xfer) begin
          state_nxt = keys_ready_r ? ST_LOAD : ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        cnt_nxt = cnt_r + rnd_t'(1);
        if (last_round) begin
          state_nxt      = ST_LOAD;
          keys_ready_nxt = 1'b1;
        end
      end
      ST_LOAD: begin
        cnt_nxt   = '0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (advance) begin
          cnt_nxt = cnt_r + rnd_t'(1);
        end
        if (finish) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // Any key word write forces a fresh expansion on the next block.
    if (cfg_xfer && (cfg_index == REG_KEY0 || cfg_index == REG_KEY1 ||
                     cfg_index == REG_KEY2 || cfg_index == REG_KEY3)) begin
      keys_ready_nxt = 1'b0;
    end
  end

  // Working words: load the key or the block, shift by one word per round.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      w_nxt[i] = w_r[i];
    end
    if (in_xfer && !keys_ready_r) begin
      for (int i = 0; i < 4; i++) begin
        w_nxt[i] = key_r[i] ^ FK[i];
      end
    end else if (state_r == ST_LOAD) begin
      for (int i = 0; i < 4; i++) begin
        w_nxt[i] = blk_r[i];
      end
    end else if (state_r == ST_EXPAND || advance) begin
      w_nxt[0] = w_r[1];
      w_nxt[1] = w_r[2];
      w_nxt[2] = w_r[3];
      w_nxt[3] = nx;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      keys_ready_r <= 1'b0;
      out_valid_r  <= 1'b0;
      mode_r       <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      keys_ready_r <= keys_ready_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_xfer) begin
        case (cfg_index)
          REG_KEY0: key_r[0] <= cfg_data;
          REG_KEY1: key_r[1] <= cfg_data;
          REG_KEY2: key_r[2] <= cfg_data;
          REG_KEY3: key_r[3] <= cfg_data;
          REG_MODE: mode_r   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      w_r[i] <= w_nxt[i];
    end
    if (in_xfer) begin
      blk_r[0] <= in_block_word0;
      blk_r[1] <= in_block_word1;
      blk_r[2] <= in_block_word2;
      blk_r[3] <= in_block_word3;
    end
    if (finish) begin
      res_r[0] <= nx;
      res_r[1] <= w_r[3];
      res_r[2] <= w_r[2];
      res_r[3] <= w_r[1];
    end
  end

  // Round-key memory: written during expansion, read one round ahead.
  always_ff @(posedge clk) begin
    if (state_r == ST_EXPAND) begin
      rk_mem[cnt_r] <= nx;
    end
    if (rk_rd_en) begin
      rk_q_r <= rk_mem[rd_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_word0 = res_r[0];
  assign out_result_word1 = res_r[1];
  assign out_result_word2 = res_r[2];
  assign out_result_word3 = res_r[3];

  // A result appears only at the end of the last round.
  a_result_from_round: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_ROUND) && $past(last_round))
    else $error("result raised outside the last round");

  // Expansion never runs while the round keys are marked ready.
  a_expand_needs_stale: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXPAND) |-> !keys_ready_r)
    else $error("key expansion with keys already ready");

  // Rounds always start from round zero.
  a_round_starts_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |=> (state_r == ST_ROUND) && (cnt_r == '0))
    else $error("round counter not cleared at round start");

  // The last round never overwrites a waiting result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> !$rose(out_valid_r) && $stable(res_r[0]))
    else $error("waiting result overwritten");

endmodule

/* test/sm4_block_cipher_test.sv */
// Self-checking testbench for the SM4 block cipher with a scoreboard and random traffic.
`timescale 1ns / 1ps

module sm4_block_cipher_test;
  import sm4_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 10;
  localparam int RANDOM_BLOCKS = 1800;
  localparam int CALM_BLOCKS   = 200;
  localparam int DRAIN_CYCLES  = 80;
  localparam int CYCLE_LIMIT   = 1000000;

  // Register map of the configuration port.
  localparam logic [2:0] KEY_WORD0    = 3'd0;
  localparam logic [2:0] KEY_WORD1    = 3'd1;
  localparam logic [2:0] KEY_WORD2    = 3'd2;
  localparam logic [2:0] KEY_WORD3    = 3'd3;
  localparam logic [2:0] DECRYPT_MODE = 3'd4;

  localparam word_t MODE_ENCRYPT = 32'd0;
  localparam word_t MODE_DECRYPT = 32'd1;

  typedef struct packed {
    word_t word0, word1, word2, word3;
  } block_t;

  // Tracks key and mode, expands keys on demand and holds the expected cipher outputs.
  class cipher_scoreboard;
    word_t  key_words [4];
    logic   decrypt;
    word_t  round_keys [RoundCount];
    logic   keys_valid;
    block_t expected_q [$];
    int     mismatches;
    int     blocks_in;
    int     results_out;
    int     key_loads;
    int     decrypt_blocks;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      decrypt        = 1'b0;
      keys_valid     = 1'b0;
      mismatches     = 0;
      blocks_in      = 0;
      results_out    = 0;
      key_loads      = 0;
      decrypt_blocks = 0;
    endfunction

    function word_t rotl(word_t v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function word_t sub_bytes(word_t v);
      return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function word_t mix_data(word_t v);
      word_t b;
      b = sub_bytes(v);
      return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    function word_t mix_key(word_t v);
      word_t b;
      b = sub_bytes(v);
      return b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    // Byte j of constant i is (4*i + j) * 7, kept to eight bits.
    function word_t ck_word(int i);
      word_t c;
      c = '0;
      for (int j = 0; j < 4; j++) c = {c[23:0], 8'((4 * i + j) * 7)};
      return c;
    endfunction

    function void expand_key();
      word_t k [4];
      word_t nk;
      for (int i = 0; i < 4; i++) k[i] = key_words[i] ^ FK[i];
      for (int r = 0; r < RoundCount; r++) begin
        nk = k[0] ^ mix_key(k[1] ^ k[2] ^ k[3] ^ ck_word(r));
        k[0] = k[1];
        k[1] = k[2];
        k[2] = k[3];
        k[3] = nk;
        round_keys[r] = nk;
      end
      keys_valid = 1'b1;
      key_loads++;
    endfunction

    function void note_config(logic [2:0] index, word_t data);
      if (index <= KEY_WORD3) begin
        key_words[index] = data;
        keys_valid       = 1'b0;
      end else if (index == DECRYPT_MODE) begin
        decrypt = data[0];
      end
      // Any other index addresses no register and changes nothing.
    endfunction

    function void note_block(block_t blk);
      word_t  x [4];
      word_t  rk;
      word_t  nx;
      block_t res;
      if (!keys_valid) expand_key();
      x[0] = blk.word0;
      x[1] = blk.word1;
      x[2] = blk.word2;
      x[3] = blk.word3;
      for (int r = 0; r < RoundCount; r++) begin
        rk = decrypt ? round_keys[RoundCount - 1 - r] : round_keys[r];
        nx = x[0] ^ mix_data(x[1] ^ x[2] ^ x[3] ^ rk);
        x[0] = x[1];
        x[1] = x[2];
        x[2] = x[3];
        x[3] = nx;
      end
      // The output words come out in reverse order.
      res.word0 = x[3];
      res.word1 = x[2];
      res.word2 = x[1];
      res.word3 = x[0];
      expected_q.push_back(res);
      blocks_in++;
      if (decrypt) decrypt_blocks++;
    endfunction

    function void check_result(block_t got);
      block_t exp_blk;
      if (expected_q.size() == 0) begin
        $error("result %h arrived with no block outstanding", got);
        mismatches++;
        return;
      end
      exp_blk = expected_q.pop_front();
      results_out++;
      if (got.word0 !== exp_blk.word0) begin
        $error("result_word0: expected %h, got %h", exp_blk.word0, got.word0);
        mismatches++;
      end
      if (got.word1 !== exp_blk.word1) begin
        $error("result_word1: expected %h, got %h", exp_blk.word1, got.word1);
        mismatches++;
      end
      if (got.word2 !== exp_blk.word2) begin
        $error("result_word2: expected %h, got %h", exp_blk.word2, got.word2);
        mismatches++;
      end
      if (got.word3 !== exp_blk.word3) begin
        $error("result_word3: expected %h, got %h", exp_blk.word3, got.word3);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  word_t      in_block_word0 = '0;
  word_t      in_block_word1 = '0;
  word_t      in_block_word2 = '0;
  word_t      in_block_word3 = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  word_t      out_result_word0;
  word_t      out_result_word1;
  word_t      out_result_word2;
  word_t      out_result_word3;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  word_t      cfg_data  = '0;

  cipher_scoreboard sb;
  bit feed_idling = 1'b1;
  bit sink_idling = 1'b1;
  int cycle_count = 0;

  sm4_block_cipher u_dut (.*);

  always #(CLK_HALF) clk = ~clk;

  // Watch every transfer on the three channels.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.note_config(cfg_index, cfg_data);
      if (in_valid && in_ready)
        sb.note_block({in_block_word0, in_block_word1, in_block_word2, in_block_word3});
      if (out_valid && out_ready)
        sb.check_result({out_result_word0, out_result_word1, out_result_word2,
                         out_result_word3});
    end
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("** sm4_block_cipher: FAILED **");
      $finish;
    end
  end

  // Result side: ready with random stall bursts while idling is enabled.
  initial begin : result_sink
    while (!rst_n) @(posedge clk);
    forever begin
      if (sink_idling && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Offer one block, after an optional gap, and hold it until the transfer.
  task automatic send_block(block_t blk);
    if (feed_idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_block_word0 <= blk.word0;
    in_block_word1 <= blk.word1;
    in_block_word2 <= blk.word2;
    in_block_word3 <= blk.word3;
    do @(posedge clk); while (!in_ready);
  endtask

  // One register write, after which the channel is left idle.
  task automatic write_reg(logic [2:0] index, word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering blocks and wait until every outstanding result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  initial begin : stimulus
    block_t blk;
    int     phase_len;
    int     sent;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset key of all zeros, encrypting.
    send_block('0);
    send_block('1);
    drain_results();

    // Published test key and plaintext.
    write_reg(KEY_WORD0, 32'h01234567);
    write_reg(KEY_WORD1, 32'h89ABCDEF);
    write_reg(KEY_WORD2, 32'hFEDCBA98);
    write_reg(KEY_WORD3, 32'h76543210);
    send_block({32'h01234567, 32'h89ABCDEF, 32'hFEDCBA98, 32'h76543210});
    send_block({32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555});
    drain_results();

    // A mode change reuses the stored round keys in reverse order.
    write_reg(DECRYPT_MODE, MODE_DECRYPT);
    send_block({32'h681EDF34, 32'hD206965E, 32'h86B3E94F, 32'h536E4246});
    drain_results();

    // Writes to unused indexes must leave key and mode alone.
    for (int idx = int'(DECRYPT_MODE) + 1; idx < (1 << $bits(cfg_index)); idx++)
      write_reg(3'(idx), $urandom);
    send_block({32'h681EDF34, 32'hD206965E, 32'h86B3E94F, 32'h536E4246});
    drain_results();

    // Only bit 0 of the mode word counts.
    write_reg(DECRYPT_MODE, 32'hFFFFFFFE);
    send_block({32'h01234567, 32'h89ABCDEF, 32'hFEDCBA98, 32'h76543210});
    drain_results();
    write_reg(DECRYPT_MODE, '1);

    // New all-ones key while decrypting: expansion happens in decrypt mode.
    write_reg(KEY_WORD0, '1);
    write_reg(KEY_WORD1, '1);
    write_reg(KEY_WORD2, '1);
    write_reg(KEY_WORD3, '1);
    send_block('1);
    send_block('0);
    send_block({4{32'hAAAAAAAA}});
    send_block({4{32'h55555555}});
    drain_results();

    // Changing one key word alone still forces a fresh expansion.
    write_reg(KEY_WORD2, 32'h80000001);
    write_reg(DECRYPT_MODE, MODE_ENCRYPT);
    send_block({32'h00000001, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFE});
    send_block({32'hFFFFFFFF, 32'h00000000, 32'h00000000, 32'hFFFFFFFF});
    drain_results();

    // Rewriting the same value re-expands to the same round keys.
    write_reg(KEY_WORD2, 32'h80000001);
    send_block({32'h01234567, 32'h89ABCDEF, 32'hFEDCBA98, 32'h76543210});
    drain_results();

    // Random phases: a random reconfiguration, then a burst of blocks.
    sent = 0;
    while (sent < RANDOM_BLOCKS) begin
      if (sent >= RANDOM_BLOCKS - CALM_BLOCKS) begin
        feed_idling = 1'b0;
        sink_idling = 1'b0;
      end else begin
        feed_idling = $urandom_range(0, 3) != 0;
        sink_idling = $urandom_range(0, 3) != 0;
      end
      for (int idx = 0; idx < (1 << $bits(cfg_index)); idx++) begin
        if (idx <= int'(DECRYPT_MODE) ? $urandom_range(0, 2) == 0 : $urandom_range(0, 15) == 0)
          write_reg(3'(idx), rand_word());
      end
      phase_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      for (int n = 0; n < phase_len && sent < RANDOM_BLOCKS; n++) begin
        blk.word0 = rand_word();
        blk.word1 = rand_word();
        blk.word2 = rand_word();
        blk.word3 = rand_word();
        send_block(blk);
        sent++;
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d blocks (%0d decrypted) through %0d key expansions; %0d results checked.",
             sb.blocks_in, sb.decrypt_blocks, sb.key_loads, sb.results_out);
    $display("Field mismatches: %0d, results still outstanding: %0d.",
             sb.mismatches, sb.expected_q.size());
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("** sm4_block_cipher: PASSED **");
    else
      $display("** sm4_block_cipher: FAILED **");
    $finish;
  end

endmodule

/* filelist.f */
src/sm4_pkg.sv
src/sm4_round.sv
src/sm4_block_cipher.sv
test/sm4_block_cipher_test.sv
